>>> hw/rtl/tmhq_pkg.sv
package tmhq_pkg;

	localparam int MAX_TIMERS = 64;
	localparam int TIME_BITS  = 48;
	localparam int NUM_IDS    = 64;
	localparam int ID_BITS    = $clog2(NUM_IDS);
	localparam int SLOT_BITS  = $clog2(MAX_TIMERS + 1);
	localparam int ADDR_BITS  = $clog2(MAX_TIMERS);

	localparam logic [1:0] MODE_ARM    = 2'd0;
	localparam logic [1:0] MODE_DISARM = 2'd1;
	localparam logic [1:0] MODE_RUN    = 2'd2;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_ARMED       = 3'd1;
	localparam logic [2:0] ST_NOT_ARMED   = 3'd2;
	localparam logic [2:0] ST_FULL        = 3'd3;
	localparam logic [2:0] ST_NONE_DUE    = 3'd4;

	typedef struct packed {
		logic [1:0]           mode;
		logic [ID_BITS-1:0]   timer_id;
		logic [TIME_BITS-1:0] time_value;
	} cmd_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   expired_id;
		logic [2:0]           status;
		logic                 last;
		logic [SLOT_BITS-1:0] armed_count;
		logic                 soonest_valid;
		logic [TIME_BITS-1:0] soonest_time;
	} rsp_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   id;
		logic [TIME_BITS-1:0] tm;
	} entry_t;

	function automatic logic [ADDR_BITS-1:0] slot_addr(input logic [SLOT_BITS:0] slot);
		logic [SLOT_BITS:0] a;
		a = slot - 1'b1;
		return a[ADDR_BITS-1:0];
	endfunction

endpackage

>>> hw/rtl/timer_min_heap_queue_top.sv
// channel  | ports              | handshake
// command  | cmd                | taken when start && !busy
// result   | rsp                | one cycle, marked by rsp_valid
// An arm puts the new entry in the last slot and moves it up the heap toward the root.
// A disarm of the last slot only shrinks the heap; else the last entry fills the slot and moves.
// A run reads the root; each expired item is removed and the last entry sifted down from the root.
// Reset empties the heap and marks every id unarmed at once.
// The result side cannot stall; busy holds off new commands.
module timer_min_heap_queue_top
	import tmhq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic rsp_valid,
	output rsp_t rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_DIS_SLOT, S_LAST_RD, S_UP_RD, S_UP_CMP,
		S_DN_RD, S_DN_CMP, S_ROOT, S_ROOT_CMP
	} state_t;

	state_t                state_q;
	logic [SLOT_BITS-1:0]  count_q;
	logic [SLOT_BITS-1:0]  s_q;
	entry_t                cur_q;
	logic [1:0]            mode_q;
	logic [TIME_BITS-1:0]  t_q;
	logic [2:0]            stat_q;
	logic                  moved_q;
	logic                  arm_q;
	logic                  pend_q;
	logic [ID_BITS-1:0]    pend_id_q;
	logic [NUM_IDS-1:0]    vld_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	entry_t                heap_mem [MAX_TIMERS];
	logic [SLOT_BITS-1:0]  slot_mem [NUM_IDS];
	entry_t                rd_a, rd_b;
	logic [SLOT_BITS-1:0]  slot_rd;

	logic                  hw_en;
	logic [ADDR_BITS-1:0]  hw_addr;
	entry_t                hw_data;
	logic [ADDR_BITS-1:0]  ra_addr, rb_addr;

	logic [SLOT_BITS-1:0]  par;
	logic [SLOT_BITS:0]    lc, rc;
	logic                  has_l, has_r, up_swap, pick_l, pick_r, root_due;
	logic [TIME_BITS-1:0]  mt;

	assign busy      = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign par      = s_q >> 1;
	assign lc       = {s_q, 1'b0};
	assign rc       = lc + 1'b1;
	assign has_l    = (lc <= {1'b0, count_q});
	assign has_r    = (rc <= {1'b0, count_q});
	assign up_swap  = (rd_a.tm > cur_q.tm);
	assign pick_l   = has_l && (cur_q.tm > rd_a.tm);
	assign mt       = pick_l ? rd_a.tm : cur_q.tm;
	assign pick_r   = has_r && (mt > rd_b.tm);
	assign root_due = (count_q != '0) && !(rd_a.tm > t_q);

	always_comb begin
		hw_en   = 1'b0;
		hw_addr = slot_addr({1'b0, s_q});
		hw_data = cur_q;
		ra_addr = '0;
		rb_addr = '0;
		unique case (state_q)
			S_UP_RD: begin
				if (s_q == SLOT_BITS'(1)) begin
					hw_en = moved_q || arm_q;
				end else begin
					ra_addr = slot_addr({1'b0, par});
				end
			end
			S_UP_CMP: begin
				if (up_swap) begin
					hw_en   = 1'b1;
					hw_data = rd_a;
				end else begin
					hw_en = moved_q || arm_q;
				end
			end
			S_DN_RD: begin
				if (!has_l) begin
					hw_en = 1'b1;
				end else begin
					ra_addr = slot_addr(lc);
					rb_addr = slot_addr(rc);
				end
			end
			S_DN_CMP: begin
				hw_en = 1'b1;
				if (pick_r) begin
					hw_data = rd_b;
				end else if (pick_l) begin
					hw_data = rd_a;
				end
			end
			S_DIS_SLOT, S_ROOT_CMP: ra_addr = slot_addr({1'b0, count_q});
			default: ra_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (hw_en) begin
			heap_mem[hw_addr]    <= hw_data;
			slot_mem[hw_data.id] <= s_q;
		end
		rd_a    <= heap_mem[ra_addr];
		rd_b    <= heap_mem[rb_addr];
		slot_rd <= slot_mem[cmd.timer_id];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			s_q         <= '0;
			mode_q      <= '0;
			stat_q      <= ST_OK;
			moved_q     <= 1'b0;
			arm_q       <= 1'b0;
			pend_q      <= 1'b0;
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q  <= cmd.mode;
						t_q     <= cmd.time_value;
						stat_q  <= ST_OK;
						moved_q <= 1'b0;
						arm_q   <= 1'b0;
						pend_q  <= 1'b0;
						state_q <= S_ROOT;
						priority case (cmd.mode)
							MODE_ARM: begin
								if (vld_q[cmd.timer_id]) begin
									stat_q <= ST_ARMED;
								end else if (count_q == SLOT_BITS'(MAX_TIMERS)) begin
									stat_q <= ST_FULL;
								end else begin
									count_q                <= count_q + 1'b1;
									s_q                    <= count_q + 1'b1;
									cur_q                  <= {cmd.timer_id, cmd.time_value};
									vld_q[cmd.timer_id]    <= 1'b1;
									arm_q                  <= 1'b1;
									state_q                <= S_UP_RD;
								end
							end
							MODE_DISARM: begin
								if (!vld_q[cmd.timer_id]) begin
									stat_q <= ST_NOT_ARMED;
								end else begin
									vld_q[cmd.timer_id] <= 1'b0;
									state_q             <= S_DIS_SLOT;
								end
							end
							default: state_q <= S_ROOT;
						endcase
					end
				end
				S_DIS_SLOT: begin
					count_q <= count_q - 1'b1;
					if (slot_rd == count_q) begin
						state_q <= S_ROOT;
					end else begin
						s_q     <= slot_rd;
						state_q <= S_LAST_RD;
					end
				end
				S_LAST_RD: begin
					cur_q   <= rd_a;
					state_q <= S_UP_RD;
				end
				S_UP_RD: begin
					if (s_q == SLOT_BITS'(1)) begin
						state_q <= (moved_q || arm_q) ? S_ROOT : S_DN_RD;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (up_swap) begin
						s_q     <= par;
						moved_q <= 1'b1;
						state_q <= S_UP_RD;
					end else begin
						state_q <= (moved_q || arm_q) ? S_ROOT : S_DN_RD;
					end
				end
				S_DN_RD: begin
					state_q <= has_l ? S_DN_CMP : S_ROOT;
				end
				S_DN_CMP: begin
					if (pick_r) begin
						s_q     <= rc[SLOT_BITS-1:0];
						state_q <= S_DN_RD;
					end else if (pick_l) begin
						s_q     <= lc[SLOT_BITS-1:0];
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					state_q <= S_ROOT_CMP;
				end
				S_ROOT_CMP: begin
					rsp_q.armed_count   <= count_q;
					rsp_q.soonest_valid <= (count_q != '0);
					rsp_q.soonest_time  <= (count_q != '0) ? rd_a.tm : '0;
					rsp_q.expired_id    <= '0;
					rsp_q.status        <= stat_q;
					rsp_q.last          <= 1'b1;
					state_q             <= S_IDLE;
					if (mode_q == MODE_RUN) begin
						rsp_valid_q <= pend_q || !root_due;
						if (pend_q) begin
							rsp_q.expired_id <= pend_id_q;
							rsp_q.status     <= ST_OK;
							rsp_q.last       <= !root_due;
						end else begin
							rsp_q.status <= ST_NONE_DUE;
						end
						if (root_due) begin
							pend_q          <= 1'b1;
							pend_id_q       <= rd_a.id;
							vld_q[rd_a.id]  <= 1'b0;
							moved_q         <= 1'b0;
							arm_q           <= 1'b0;
							s_q             <= SLOT_BITS'(1);
							count_q         <= count_q - 1'b1;
							state_q         <= (count_q == SLOT_BITS'(1)) ? S_ROOT : S_LAST_RD;
						end
					end else begin
						rsp_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
